[rtl/core/integer_to_ascii_radix_defines.svh]
// Assertion macros for the RTL; empty when SYNTHESIS is defined.
`ifndef INTEGER_TO_ASCII_RADIX_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_DEFINES_SVH

`ifndef SYNTHESIS
`define ITAR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("itar: assertion failed");
`define ITAR_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("itar: assertion failed");
`else
`define ITAR_ASSERT(lbl, prop)
`define ITAR_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[rtl/core/itar_pkg.sv]
`timescale 1ns / 1ps
package itar_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_DIGITS_DEF = 32;

    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 7;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] DECIMAL     = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

    typedef struct packed {
        logic               negative;
        logic [RADIX_W-1:0] radix;
    } t_item_ctl;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DECIMAL) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else begin
            c = CHAR_A + CHAR_W'(d - DECIMAL);
        end
        return c;
    endfunction

endpackage

[rtl/core/itar_front.sv]
`timescale 1ns / 1ps
module itar_front #(
    parameter int VALUE_BITS = itar_pkg::VALUE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [VALUE_BITS-1:0]   i_value,
    input  logic [itar_pkg::RADIX_W-1:0]   i_radix,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [VALUE_BITS-1:0]          o_mag,
    output itar_pkg::t_item_ctl            o_ctl
);
    import itar_pkg::*;

    logic                  r_valid;
    logic                  n_valid;
    logic [VALUE_BITS-1:0] r_mag;
    t_item_ctl             r_ctl;
    logic [VALUE_BITS-1:0] raw;
    logic                  neg;
    logic                  accept;

    assign raw     = i_value;
    assign neg     = (i_radix == DECIMAL) && raw[VALUE_BITS-1];
    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // take the magnitude of negative decimal values
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mag          <= neg ? (~raw + 1'b1) : raw;
            r_ctl.negative <= neg;
            r_ctl.radix    <= i_radix;
        end
    end

    assign o_valid = r_valid;
    assign o_mag   = r_mag;
    assign o_ctl   = r_ctl;

endmodule

[rtl/core/itar_queue.sv]
`timescale 1ns / 1ps
module itar_queue #(
    parameter int DATA_W = itar_pkg::VALUE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  logic [DATA_W-1:0] i_push_data,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output logic [DATA_W-1:0] o_pop_data
);
    logic [DATA_W-1:0] r_mem [2];
    logic              r_wr;
    logic              r_rd;
    logic [1:0]        r_cnt;
    logic [1:0]        n_cnt;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_data   = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

[rtl/core/itar_back.sv]
`timescale 1ns / 1ps
`include "integer_to_ascii_radix_defines.svh"
module itar_back #(
    parameter int VALUE_BITS = itar_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = itar_pkg::MAX_DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [VALUE_BITS-1:0]         i_mag,
    input  itar_pkg::t_item_ctl           i_ctl,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [itar_pkg::CHAR_W-1:0]   o_char_code,
    output logic                          o_last
);
    import itar_pkg::*;

    localparam int BIT_W = $clog2(VALUE_BITS);
    localparam int IDX_W = $clog2(MAX_DIGITS);
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_SIGN = 5'b00100,
        S_RD   = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic [VALUE_BITS-1:0] r_quo, n_quo;
    logic [RADIX_W-1:0]   r_rem, n_rem;
    logic [BIT_W-1:0]     r_bit, n_bit;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_neg, n_neg;
    logic [RADIX_W-1:0]   r_radix, n_radix;
    logic                 r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]    r_out_char, n_out_char;
    logic                 r_out_last, n_out_last;

    logic [RADIX_W-1:0]   r_mem [MAX_DIGITS];
    logic [RADIX_W-1:0]   r_rd_data;

    logic [RADIX_W:0]     rem_sh;
    logic [RADIX_W:0]     rem_dif;
    logic                 ge;
    logic [RADIX_W-1:0]   rem_nx;
    logic [VALUE_BITS-1:0] quo_nx;
    logic                 digit_done;
    logic                 wr_en;
    logic [CNT_W-1:0]     cnt_m1;
    logic [IDX_W-1:0]     rd_addr;
    logic                 out_free;
    logic                 load;

    // one restoring division step per cycle
    assign rem_sh     = {r_rem, r_quo[VALUE_BITS-1]};
    assign rem_dif    = rem_sh - {1'b0, r_radix};
    assign ge         = (rem_sh >= {1'b0, r_radix});
    assign rem_nx     = ge ? rem_dif[RADIX_W-1:0] : rem_sh[RADIX_W-1:0];
    assign quo_nx     = {r_quo[VALUE_BITS-2:0], ge};
    assign digit_done = (r_state == S_DIV) && (r_bit == '0);
    assign wr_en      = digit_done && (r_cnt < CNT_W'(MAX_DIGITS));
    assign cnt_m1     = r_cnt - 1'b1;
    assign rd_addr    = cnt_m1[IDX_W-1:0];
    assign out_free   = !r_out_valid || i_ready;
    assign o_ready    = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_bit       = r_bit;
        n_cnt       = r_cnt;
        n_neg       = r_neg;
        n_radix     = r_radix;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        load        = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_quo   = i_mag;
                    n_rem   = '0;
                    n_bit   = BIT_W'(VALUE_BITS - 1);
                    n_cnt   = '0;
                    n_neg   = i_ctl.negative;
                    n_radix = i_ctl.radix;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_quo = quo_nx;
                n_rem = rem_nx;
                n_bit = r_bit - 1'b1;
                if (digit_done) begin
                    n_rem = '0;
                    n_bit = BIT_W'(VALUE_BITS - 1);
                    if (wr_en) begin
                        n_cnt = r_cnt + 1'b1;
                    end
                    if (quo_nx == '0) begin
                        n_state = r_neg ? S_SIGN : S_RD;
                    end
                end
            end
            S_SIGN: begin
                if (out_free) begin
                    load       = 1'b1;
                    n_out_char = CHAR_MINUS;
                    n_out_last = 1'b0;
                    n_state    = S_RD;
                end
            end
            S_RD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    load       = 1'b1;
                    n_out_char = digit_char(r_rd_data);
                    n_out_last = (r_cnt == CNT_W'(1));
                    n_cnt      = cnt_m1;
                    n_state    = (r_cnt == CNT_W'(1)) ? S_IDLE : S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bit       <= '0;
            r_cnt       <= '0;
            r_neg       <= 1'b0;
            r_radix     <= RADIX_RESET;
            r_out_valid <= 1'b0;
            r_quo       <= '0;
            r_rem       <= '0;
        end else begin
            r_state     <= n_state;
            r_bit       <= n_bit;
            r_cnt       <= n_cnt;
            r_neg       <= n_neg;
            r_radix     <= n_radix;
            r_out_valid <= n_out_valid;
            r_quo       <= n_quo;
            r_rem       <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    // digit store: write at the digit count, read below it
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_cnt[IDX_W-1:0]] <= rem_nx;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_valid     = r_out_valid;
    assign o_char_code = r_out_char;
    assign o_last      = r_out_last;

    `ITAR_ASSERT(a_rem_below_radix, (r_state == S_DIV) |-> (r_rem < r_radix))
    `ITAR_ASSERT(a_out_has_digit, (r_state == S_OUT) |-> (r_cnt != '0))
    `ITAR_ASSERT(a_cnt_bound, r_cnt <= CNT_W'(MAX_DIGITS))

endmodule

[rtl/core/integer_to_ascii_radix.sv]
`timescale 1ns / 1ps
// Integer to ASCII string conversion in a configurable radix (2 to 36).
// Input channel: i_valid / o_ready carry one signed i_value per transfer.
// Output channel: o_valid / i_ready carry one character per transfer,
// most significant digit first; o_last marks the final character.
// Radix 10 prefixes a '-' for negative values; other radixes convert the
// raw two's-complement pattern. Zero yields the single character '0'.
// Config: i_cfg_we writes i_cfg_wdata into the radix register, saturated
// to 2..36; write only while no conversion is in flight.
// Values pass the input register and the two-entry queue into the
// converter; each digit takes a full pass of the bit-serial divider,
// and each character passes a read state and an output state. The
// converter takes one value at a time and the next only once the last
// character is loaded; the queue lets the input take values meanwhile.
// Reset (i_rst_n low, synchronous) empties all stages and sets radix 10.
// A stalled receiver holds the current character; emission pauses, division goes on.
module integer_to_ascii_radix #(
    parameter int VALUE_BITS = itar_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = itar_pkg::MAX_DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [VALUE_BITS-1:0]  i_value,
    input  logic                          i_cfg_we,
    input  logic [itar_pkg::RADIX_W-1:0]  i_cfg_wdata,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [itar_pkg::CHAR_W-1:0]   o_char_code,
    output logic                          o_last
);
    import itar_pkg::*;

    localparam int CTL_W  = $bits(t_item_ctl);
    localparam int DATA_W = VALUE_BITS + CTL_W;

    logic [RADIX_W-1:0]    r_radix;
    logic [RADIX_W-1:0]    n_radix;

    logic                  f_valid;
    logic                  f_ready;
    logic [VALUE_BITS-1:0] f_mag;
    t_item_ctl             f_ctl;

    logic                  q_valid;
    logic                  q_ready;
    logic [DATA_W-1:0]     q_data;
    t_item_ctl             q_ctl;

    always_comb begin
        n_radix = i_cfg_wdata;
        if (i_cfg_wdata < RADIX_MIN) begin
            n_radix = RADIX_MIN;
        end else if (i_cfg_wdata > RADIX_MAX) begin
            n_radix = RADIX_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_cfg_we) begin
            r_radix <= n_radix;
        end
    end

    itar_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_value (i_value),
        .i_radix (r_radix),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_mag   (f_mag),
        .o_ctl   (f_ctl)
    );

    itar_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_data  ({f_ctl, f_mag}),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_data   (q_data)
    );

    assign q_ctl = t_item_ctl'(q_data[DATA_W-1:VALUE_BITS]);

    itar_back #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .o_ready     (q_ready),
        .i_mag       (q_data[VALUE_BITS-1:0]),
        .i_ctl       (q_ctl),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
    import itar_pkg::*;

    localparam int VALUE_BITS  = VALUE_BITS_DEF;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int BURST_ITEMS = 24;
    localparam int HOLD_CYCLES = 3000;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_char_beat;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_valid     = 1'b0;
    logic signed [VALUE_BITS-1:0] i_value     = '0;
    logic                         i_cfg_we    = 1'b0;
    logic [RADIX_W-1:0]           i_cfg_wdata = '0;
    logic                         i_ready     = 1'b0;
    logic                         o_ready;
    logic                         o_valid;
    logic [CHAR_W-1:0]            o_char_code;
    logic                         o_last;

    t_char_beat         pending_chars[$];
    logic [RADIX_W-1:0] radix_q       = RADIX_RESET;
    int unsigned        send_gap_pct  = 0;
    int unsigned        recv_idle_pct = 0;
    int unsigned        hold_request  = 0;
    int unsigned        stall_left    = 0;
    int unsigned        cycle_count   = 0;
    int unsigned        err_count     = 0;
    int unsigned        items_sent    = 0;
    int unsigned        chars_checked = 0;
    int unsigned        radix_writes  = 0;

    integer_to_ascii_radix uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_value     (i_value),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            stall_left   = hold_request;
            hold_request = 0;
        end
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_char_beat want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_chars.size() == 0) begin
                $error("unexpected character 0x%02h last=%0b", o_char_code, o_last);
                err_count++;
            end else begin
                want = pending_chars.pop_front();
                chars_checked++;
                if (o_char_code !== want.code) begin
                    $error("char_code: expected 0x%02h, got 0x%02h", want.code, o_char_code);
                    err_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_last);
                    err_count++;
                end
            end
        end
    end

    function automatic void spell_value(input logic [VALUE_BITS-1:0] v);
        logic [VALUE_BITS-1:0] mag;
        logic                  neg;
        logic [RADIX_W-1:0]    digits[$];
        t_char_beat            beat;
        neg = (radix_q == DECIMAL) && v[VALUE_BITS-1];
        mag = neg ? (~v + 1'b1) : v;
        do begin
            digits.push_back(RADIX_W'(mag % radix_q));
            mag = mag / radix_q;
        end while (mag != 0);
        if (neg) begin
            beat.code = CHAR_MINUS;
            beat.last = 1'b0;
            pending_chars.push_back(beat);
        end
        for (int k = digits.size() - 1; k >= 0; k--) begin
            if (digits[k] < DECIMAL) begin
                beat.code = CHAR_ZERO + CHAR_W'(digits[k]);
            end else begin
                beat.code = CHAR_A + CHAR_W'(digits[k] - DECIMAL);
            end
            beat.last = (k == 0);
            pending_chars.push_back(beat);
        end
    endfunction

    function automatic logic [VALUE_BITS-1:0] random_value();
        logic [VALUE_BITS-1:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = $urandom_range(0, 40);
            2: v = -$urandom_range(1, 40);
            3: v = $urandom >> $urandom_range(0, VALUE_BITS - 1);
            4: v = -($urandom >> $urandom_range(0, VALUE_BITS - 1));
            default: begin
                case ($urandom_range(0, 3))
                    0: v = {1'b1, {(VALUE_BITS-1){1'b0}}};
                    1: v = {1'b0, {(VALUE_BITS-1){1'b1}}};
                    2: v = '1;
                    default: v = '0;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic logic [RADIX_W-1:0] random_radix();
        logic [RADIX_W-1:0] r;
        case ($urandom_range(0, 4))
            0, 1: r = DECIMAL;
            2: r = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
            3: r = RADIX_W'($urandom_range(0, (1 << RADIX_W) - 1));
            default: r = ($urandom_range(0, 1) != 0) ? RADIX_MIN : RADIX_MAX;
        endcase
        return r;
    endfunction

    task automatic write_radix(input logic [RADIX_W-1:0] w);
        i_cfg_wdata <= w;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (w < RADIX_MIN) begin
            radix_q = RADIX_MIN;
        end else if (w > RADIX_MAX) begin
            radix_q = RADIX_MAX;
        end else begin
            radix_q = w;
        end
        radix_writes++;
    endtask

    task automatic send_value(input logic [VALUE_BITS-1:0] v);
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (!o_ready);
        spell_value(v);
        items_sent++;
    endtask

    task automatic drop_valid();
        i_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (pending_chars.size() != 0);
    endtask

    task automatic test_decimal_corners();
        logic [VALUE_BITS-1:0] vals[$];
        vals = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'd123456789, -32'sd987654321};
        foreach (vals[i]) send_value(vals[i]);
        drop_valid();
        wait_drained();
    endtask

    task automatic test_radix_limits();
        write_radix(6'd0);
        send_value(32'hFFFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'd5);
        drop_valid();
        wait_drained();
        write_radix(6'd1);
        send_value(32'd1);
        drop_valid();
        wait_drained();
        write_radix(RADIX_MAX);
        send_value(32'd35);
        send_value(32'hFFFF_FFFF);
        send_value(32'd1295);
        drop_valid();
        wait_drained();
        write_radix(6'd37);
        send_value(32'd36);
        drop_valid();
        wait_drained();
        write_radix(6'd63);
        send_value(32'h7FFF_FFFF);
        drop_valid();
        wait_drained();
        write_radix(6'd16);
        send_value(32'hDEAD_BEEF);
        drop_valid();
        wait_drained();
    endtask

    task automatic test_random_traffic(input int unsigned gap_pct, input int unsigned idle_pct,
                                       input int n_items);
        send_gap_pct  = gap_pct;
        recv_idle_pct = idle_pct;
        for (int i = 0; i < n_items; i++) begin
            if (i % BURST_ITEMS == 0) begin
                if (i != 0) begin
                    drop_valid();
                    wait_drained();
                end
                write_radix(random_radix());
            end
            send_value(random_value());
        end
        drop_valid();
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        send_gap_pct  = 0;
        recv_idle_pct = 0;
        write_radix(6'd16);
        hold_request = HOLD_CYCLES;
        @(posedge i_clk);
        for (int i = 0; i < 12; i++) send_value($urandom);
        drop_valid();
        wait_drained();
    endtask

    initial begin
        send_gap_pct  = 25;
        recv_idle_pct = 74;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_decimal_corners();
        test_radix_limits();
        test_random_traffic(25, 74, 146);
        test_random_traffic(74, 25, 146);
        test_random_traffic(0, 0, 146);
        test_output_backpressure();
        repeat (50) @(posedge i_clk);
        if (pending_chars.size() != 0) begin
            $error("%0d characters never arrived", pending_chars.size());
            err_count++;
        end
        $display("Converted %0d values over %0d radix writes (saturating writes included),",
                 items_sent, radix_writes);
        $display("checked %0d characters under three idle profiles and a %0d-cycle stall.",
                 chars_checked, HOLD_CYCLES);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/itar_pkg.sv
rtl/core/itar_front.sv
rtl/core/itar_queue.sv
rtl/core/itar_back.sv
rtl/core/integer_to_ascii_radix.sv
verif/tb_top.sv
